[rtl/assert_macros.svh]
// assertion macros, included by ranked_suggestion_list
// define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

[rtl/rsl_pkg.sv]
// shared types and constants of the ranked suggestion list
// used by rsl_cell and ranked_suggestion_list
`default_nettype none

package rsl_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int SCORE_W  = 8;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int ECOUNT_W = 7;

  localparam int IN_W  = 48;
  localparam int OUT_W = 56;

  // input beat field offsets
  localparam int IN_OP_LSB    = 0;
  localparam int IN_KEY_LSB   = IN_OP_LSB + OP_W;
  localparam int IN_SCORE_LSB = IN_KEY_LSB + KEY_W;
  localparam int IN_POS_LSB   = IN_SCORE_LSB + SCORE_W;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ABOVE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd4;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    logic eval;  // compare the broadcast pair against the held entry
    logic ins;   // commit the insert: keep, take new pair or shift
    logic clr;   // drop the held entry
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/rsl_cell.sv]
// one rank slot of the suggestion list chain
// depends on rsl_pkg
`default_nettype none

module rsl_cell
  import rsl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cell_ctl_t          ctl,
  input  wire logic [KEY_W-1:0]   new_key,
  input  wire logic [SCORE_W-1:0] new_score,
  input  wire logic               prev_pass,
  input  wire entry_t             prev_ent,
  output logic                    pass,
  output logic                    dup,
  output entry_t                  ent
);

  logic match;

  assign match = ent.valid && (new_score >= ent.score);

  always_ff @(posedge clk) begin
    if (rst) begin
      pass <= 1'b0;
      dup  <= 1'b0;
    end else if (ctl.eval) begin
      pass <= match;
      dup  <= match && (ent.key == new_key);
    end
  end

  // entries at or below the new score stay, the first one past takes the
  // new pair, the rest take their upper neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (ctl.clr) begin
      ent.valid <= 1'b0;
    end else if (ctl.ins && !pass) begin
      if (prev_pass) begin
        ent.valid <= 1'b1;
        ent.key   <= new_key;
        ent.score <= new_score;
      end else begin
        ent.valid <= prev_ent.valid;
        ent.key   <= prev_ent.key;
        ent.score <= prev_ent.score;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/ranked_suggestion_list.sv]
// Ranked suggestion list. Holds up to CAPACITY (64) key/score pairs sorted
// by ascending score in a chain of slot cells, one pair per cell. Every
// beat gives one result beat. When a beat is taken, each cell compares the
// new pair with its own entry; once the output register is free, the block
// gathers the cell flags, commits the insert (every cell keeps, takes the
// new pair or takes its neighbor's entry at once) or the clear, or selects
// the read slot, and loads the output register. A new beat is taken while
// the previous result still waits in the output register. The user must
// write max_score through cfg_we/cfg_wdata only while the block is idle;
// the block does not enforce this. No clearing pass is needed after reset.
`default_nettype none

module ranked_suggestion_list
  import rsl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [7:0]       cfg_wdata,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // op[1:0], key[33:2], score[41:34], position[47:42]
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // status[2:0], entry_valid[3], entry_key[35:4], entry_score[43:36],
  // entry_count[50:44], zero fill above
  output logic [OUT_W-1:0]      m_tdata
);

  `include "assert_macros.svh"

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                state;
  logic [SCORE_W-1:0]  max_score;
  logic [OP_W-1:0]     op_q;
  logic [KEY_W-1:0]    key_q;
  logic [SCORE_W-1:0]  score_q;
  logic [POS_W-1:0]    pos_q;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;

  logic                accept;
  logic                commit;
  logic [KEY_W-1:0]    bcast_key;
  logic [SCORE_W-1:0]  bcast_score;
  cell_ctl_t           ctl;

  entry_t              ent  [CAPACITY];
  logic [CAPACITY-1:0] pass;
  logic [CAPACITY-1:0] dup;

  logic                dup_any;
  logic                ins_ok;
  logic [STATUS_W-1:0] status;
  logic                rd_hit;
  entry_t              rd_ent;
  logic                res_valid;
  logic [KEY_W-1:0]    res_key;
  logic [SCORE_W-1:0]  res_score;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign commit   = (state == ST_EXEC) && (!m_tvalid || m_tready);

  // the cells compare at the accept edge, so broadcast the live beat then
  assign bcast_key   = (state == ST_IDLE) ? s_tdata[IN_KEY_LSB +: KEY_W] : key_q;
  assign bcast_score = (state == ST_IDLE) ? s_tdata[IN_SCORE_LSB +: SCORE_W] : score_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_score <= 8'd4;
    end else if (cfg_we) begin
      max_score <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= s_tdata[IN_OP_LSB +: OP_W];
      key_q   <= s_tdata[IN_KEY_LSB +: KEY_W];
      score_q <= s_tdata[IN_SCORE_LSB +: SCORE_W];
      pos_q   <= s_tdata[IN_POS_LSB +: POS_W];
    end
  end

  assign dup_any = |dup;

  always_comb begin
    status = ST_DONE;
    ins_ok = 1'b0;
    if (op_q == OP_INSERT) begin
      if (score_q > max_score) begin
        status = ST_ABOVE;
      end else if (count == CNT_W'(CAPACITY)) begin
        status = ST_FULL;
      end else if (dup_any) begin
        status = ST_DUPLICATE;
      end else begin
        status = ST_INSERTED;
        ins_ok = 1'b1;
      end
    end
  end

  assign ctl.eval = accept;
  assign ctl.ins  = commit && ins_ok;
  assign ctl.clr  = commit && (op_q == OP_CLEAR);

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
        rsl_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .ctl       (ctl),
          .new_key   (bcast_key),
          .new_score (bcast_score),
          .prev_pass (1'b1),
          .prev_ent  ('0),
          .pass      (pass[i]),
          .dup       (dup[i]),
          .ent       (ent[i])
        );
      end else begin : g_body
        rsl_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .ctl       (ctl),
          .new_key   (bcast_key),
          .new_score (bcast_score),
          .prev_pass (pass[i-1]),
          .prev_ent  (ent[i-1]),
          .pass      (pass[i]),
          .dup       (dup[i]),
          .ent       (ent[i])
        );
      end
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctl.clr) begin
      count_next = '0;
    end else if (ctl.ins) begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // read slot select
  always_comb begin
    rd_ent = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (32'(pos_q) == 32'(i)) begin
        rd_ent = ent[i];
      end
    end
  end

  assign rd_hit    = (op_q == OP_READ) && (32'(pos_q) < 32'(count));
  assign res_valid = rd_hit;
  assign res_key   = rd_hit ? rd_ent.key : '0;
  assign res_score = rd_hit ? rd_ent.score : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {(OUT_W - STATUS_W - 1 - KEY_W - SCORE_W - ECOUNT_W)'(0),
                  ECOUNT_W'(count_next), res_score, res_key, res_valid, status};
    end
  end

  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(CAPACITY))
  `ASSERT_NEXT(a_insert_count, clk, rst, ctl.ins, count == $past(count) + CNT_W'(1))
  `ASSERT_IMPLIES(a_no_accept_in_exec, clk, rst, state == ST_EXEC, !s_tready)
  `ASSERT_NEXT(a_result_follows, clk, rst, commit, m_tvalid && state == ST_IDLE)

endmodule

`default_nettype wire
